// File: src/ifc_pkg.sv
package ifc_pkg;

    localparam int MAX_SIDE     = 256;
    localparam int SIDE_W       = 9;
    localparam int PAL_SIZE     = 256;
    localparam int PAL_AW       = $clog2(PAL_SIZE);
    localparam int CANVAS_CELLS = MAX_SIDE * MAX_SIDE;
    localparam int CELL_AW      = $clog2(CANVAS_CELLS);
    localparam int COORD_W      = 10;
    localparam int PROD_W       = COORD_W + SIDE_W;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_PIXEL = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        DISP_NONE       = 3'd0,
        DISP_KEEP       = 3'd1,
        DISP_BACKGROUND = 3'd2
    } disposal_t;

    typedef enum logic [1:0] {
        CFG_CANVAS_WIDTH  = 2'd0,
        CFG_CANVAS_HEIGHT = 2'd1,
        CFG_BACKGROUND    = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAL,
        S_BG_RD,
        S_FILL,
        S_PIX_MUL,
        S_PIX_WR,
        S_RD_MUL,
        S_RD_CMP,
        S_RESP
    } state_t;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (v > SIDE_W'(MAX_SIDE))
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

// File: src/indexed_frame_compositor_unit.sv
// Palette-indexed frame compositor on a 256 x 256 RGBA canvas. Every accepted item gives
// exactly one result item (zero color for load, begin-frame and pixel; for a read the canvas
// pixel, or zero if the address is not below width * height). One item is worked on at a
// time and in_stall is high meanwhile; the result waits in an output register so the next
// item can be taken before it is collected. States per item: palette load S_PAL, S_RESP;
// keep begin-frame S_RESP; pixel S_PIX_MUL, S_PIX_WR, S_RESP; read S_RD_MUL, S_RD_CMP,
// S_RESP; clear begin-frame S_FILL, S_RESP; background begin-frame S_BG_RD, S_FILL, S_RESP
// (S_FILL writes one canvas word per cycle through the single canvas write port, and
// S_BG_RD reads the background color from the palette). A pixel and a read each pass once
// through the single 10 x 9 multiplier that forms row * width and width * height.
// Canvas contents before the first begin-frame are undefined.
module indexed_frame_compositor_unit
    import ifc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [SIDE_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic [7:0]            color_index,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [2:0]            disposal,
    input  logic                  transparency_on,
    input  logic [7:0]            rect_left,
    input  logic [7:0]            rect_top,
    input  logic [SIDE_W-1:0]     rect_width,
    input  logic [SIDE_W-1:0]     rect_height,
    input  logic [CELL_AW-1:0]    read_address,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_red,
    output logic [7:0]            out_green,
    output logic [7:0]            out_blue,
    output logic [7:0]            out_alpha
);

    state_t              state_reg, state_next;

    logic [SIDE_W-1:0]   cw_reg, ch_reg;
    logic [7:0]          bg_reg;

    logic                first_frame_reg, first_frame_next;
    logic                keep_reg, keep_next;
    logic                trans_en_reg, trans_en_next;
    logic [7:0]          trans_idx_reg, trans_idx_next;
    logic [7:0]          left_reg, left_next;
    logic [7:0]          top_reg, top_next;
    logic [SIDE_W-1:0]   rect_w_reg, rect_w_next;
    logic [SIDE_W-1:0]   rect_h_reg, rect_h_next;
    logic [SIDE_W-1:0]   cur_col_reg, cur_col_next;
    logic [SIDE_W-1:0]   cur_row_reg, cur_row_next;
    logic                fill_bg_reg, fill_bg_next;
    logic [CELL_AW-1:0]  fill_cnt_reg, fill_cnt_next;

    opcode_t             op_reg;
    logic [7:0]          idx_reg;
    logic [23:0]         rgb_reg;
    logic [CELL_AW-1:0]  addr_reg;

    logic [PROD_W-1:0]   mul_reg;
    logic [COORD_W-1:0]  mul_a;
    logic [SIDE_W-1:0]   mul_b;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic                in_rect_reg, in_rect_next;
    logic                pix_ok_reg, pix_ok_next;
    logic                rd_ok_reg, rd_ok_next;

    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_pix_reg, out_pix_next;

    logic [23:0]         palette_mem [PAL_SIZE];
    logic [23:0]         pal_rd_reg;
    logic [PAL_AW-1:0]   pal_raddr;
    logic                pal_we;

    logic [31:0]         canvas_mem [CANVAS_CELLS];
    logic [31:0]         canvas_rd_reg;
    logic                canvas_we;
    logic [CELL_AW-1:0]  canvas_waddr;
    logic [31:0]         canvas_wdata;

    logic                accept;
    logic                out_free;
    logic [SIDE_W-1:0]   cw_clamp, ch_clamp;
    logic [COORD_W-1:0]  pix_col, pix_row;
    logic [COORD_W-1:0]  col_inc;
    logic                trans_hit;
    logic                fill_any;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cw_clamp  = clamp_side(cw_reg);
    assign ch_clamp  = clamp_side(ch_reg);
    assign fill_any  = first_frame_reg || (disposal != DISP_KEEP);

    assign out_valid = out_valid_reg;
    assign out_red   = out_pix_reg[31:24];
    assign out_green = out_pix_reg[23:16];
    assign out_blue  = out_pix_reg[15:8];
    assign out_alpha = out_pix_reg[7:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= SIDE_W'(MAX_SIDE);
            ch_reg <= SIDE_W'(MAX_SIDE);
            bg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CANVAS_WIDTH:  cw_reg <= cfg_data;
                CFG_CANVAS_HEIGHT: ch_reg <= cfg_data;
                CFG_BACKGROUND:    bg_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_LOAD:  state_next = S_PAL;
                        OP_BEGIN:
                        begin
                            if (first_frame_reg || disposal == DISP_BACKGROUND)
                                state_next = S_BG_RD;
                            else if (fill_any)
                                state_next = S_FILL;
                            else
                                state_next = S_RESP;
                        end
                        OP_PIXEL: state_next = S_PIX_MUL;
                        default:  state_next = S_RD_MUL;
                    endcase
                end
            end
            S_PAL:     state_next = S_RESP;
            S_BG_RD:   state_next = S_FILL;
            S_FILL:
            begin
                if (fill_cnt_reg == '1)
                    state_next = S_RESP;
            end
            S_PIX_MUL: state_next = S_PIX_WR;
            S_PIX_WR:  state_next = S_RESP;
            S_RD_MUL:  state_next = S_RD_CMP;
            S_RD_CMP:  state_next = S_RESP;
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        if (state_reg == S_PIX_MUL)
        begin
            mul_a = pix_row;
            mul_b = cw_clamp;
        end
        else
        begin
            mul_a = COORD_W'(ch_clamp);
            mul_b = cw_clamp;
        end
    end

    assign pix_col   = COORD_W'(left_reg) + COORD_W'(cur_col_reg);
    assign pix_row   = COORD_W'(top_reg) + COORD_W'(cur_row_reg);
    assign col_inc   = COORD_W'(cur_col_reg) + COORD_W'(1);
    assign trans_hit = trans_en_reg && (idx_reg == trans_idx_reg);
    assign pal_raddr = (state_reg == S_PIX_MUL) ? idx_reg : bg_reg;

    // datapath and control outputs
    always_comb
    begin
        first_frame_next = first_frame_reg;
        keep_next        = keep_reg;
        trans_en_next    = trans_en_reg;
        trans_idx_next   = trans_idx_reg;
        left_next        = left_reg;
        top_next         = top_reg;
        rect_w_next      = rect_w_reg;
        rect_h_next      = rect_h_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        fill_bg_next     = fill_bg_reg;
        fill_cnt_next    = fill_cnt_reg;
        col_next         = col_reg;
        in_rect_next     = in_rect_reg;
        pix_ok_next      = pix_ok_reg;
        rd_ok_next       = rd_ok_reg;
        out_valid_next   = out_valid_reg;
        out_pix_next     = out_pix_reg;
        pal_we           = 1'b0;
        canvas_we        = 1'b0;
        canvas_waddr     = fill_cnt_reg;
        canvas_wdata     = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && opcode == OP_BEGIN)
                begin
                    left_next        = rect_left;
                    top_next         = rect_top;
                    rect_w_next      = rect_width;
                    rect_h_next      = rect_height;
                    trans_en_next    = transparency_on;
                    trans_idx_next   = color_index;
                    keep_next        = !first_frame_reg && (disposal == DISP_KEEP);
                    cur_col_next     = '0;
                    cur_row_next     = '0;
                    fill_bg_next     = first_frame_reg || (disposal == DISP_BACKGROUND);
                    fill_cnt_next    = '0;
                    first_frame_next = 1'b0;
                end
            end
            S_PAL:
            begin
                pal_we = 1'b1;
            end
            S_FILL:
            begin
                canvas_we     = 1'b1;
                canvas_waddr  = fill_cnt_reg;
                canvas_wdata  = fill_bg_reg ? {pal_rd_reg, ALPHA_OPAQUE} : '0;
                fill_cnt_next = fill_cnt_reg + CELL_AW'(1);
            end
            S_PIX_MUL:
            begin
                in_rect_next = (cur_row_reg < rect_h_reg) && (cur_col_reg < rect_w_reg);
                pix_ok_next  = (cur_row_reg < rect_h_reg) && (cur_col_reg < rect_w_reg)
                               && (pix_col < COORD_W'(cw_clamp))
                               && (pix_row < COORD_W'(ch_clamp));
                col_next     = pix_col;
            end
            S_PIX_WR:
            begin
                canvas_we    = pix_ok_reg && !(trans_hit && keep_reg);
                canvas_waddr = mul_reg[CELL_AW-1:0] + CELL_AW'(col_reg);
                canvas_wdata = {pal_rd_reg, trans_hit ? ALPHA_CLEAR : ALPHA_OPAQUE};
                if (in_rect_reg)
                begin
                    if (col_inc >= COORD_W'(rect_w_reg))
                    begin
                        cur_col_next = '0;
                        cur_row_next = cur_row_reg + SIDE_W'(1);
                    end
                    else
                    begin
                        cur_col_next = col_inc[SIDE_W-1:0];
                    end
                end
            end
            S_RD_CMP:
            begin
                rd_ok_next = PROD_W'(addr_reg) < mul_reg;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = (op_reg == OP_READ && rd_ok_reg) ? canvas_rd_reg : '0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            first_frame_reg <= 1'b1;
            keep_reg        <= 1'b0;
            trans_en_reg    <= 1'b0;
            trans_idx_reg   <= '0;
            left_reg        <= '0;
            top_reg         <= '0;
            rect_w_reg      <= '0;
            rect_h_reg      <= '0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            fill_bg_reg     <= 1'b0;
            fill_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            first_frame_reg <= first_frame_next;
            keep_reg        <= keep_next;
            trans_en_reg    <= trans_en_next;
            trans_idx_reg   <= trans_idx_next;
            left_reg        <= left_next;
            top_reg         <= top_next;
            rect_w_reg      <= rect_w_next;
            rect_h_reg      <= rect_h_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            fill_bg_reg     <= fill_bg_next;
            fill_cnt_reg    <= fill_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode_t'(opcode);
            idx_reg  <= color_index;
            rgb_reg  <= {red, green, blue};
            addr_reg <= read_address;
        end
        mul_reg     <= PROD_W'(mul_a) * PROD_W'(mul_b);
        col_reg     <= col_next;
        in_rect_reg <= in_rect_next;
        pix_ok_reg  <= pix_ok_next;
        rd_ok_reg   <= rd_ok_next;
        out_pix_reg <= out_pix_next;
    end

    // palette memory
    always_ff @(posedge clk)
    begin
        if (pal_we)
            palette_mem[idx_reg] <= rgb_reg;
        pal_rd_reg <= palette_mem[pal_raddr];
    end

    // canvas memory
    always_ff @(posedge clk)
    begin
        if (canvas_we)
            canvas_mem[canvas_waddr] <= canvas_wdata;
        canvas_rd_reg <= canvas_mem[addr_reg];
    end

    // a result only appears after the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_RESP))
        else $error("result item raised outside response state");

    // the column cursor never runs past the frame width
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_col_reg != '0) |-> (cur_col_reg < rect_w_reg))
        else $error("column cursor beyond frame width");

    // a read item goes straight to the multiplier
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_READ) |=> (state_reg == S_RD_MUL))
        else $error("read item did not start bound check");

endmodule

// File: sim/indexed_frame_compositor_unit_tb.sv
`timescale 1ns / 1ps

module indexed_frame_compositor_unit_tb;
    import ifc_pkg::*;

    typedef struct {
        opcode_t                op;
        logic [7:0]             color_index;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
        logic [2:0]             disposal;
        logic                   transparency_on;
        logic [7:0]             rect_left;
        logic [7:0]             rect_top;
        logic [SIDE_W-1:0]      rect_width;
        logic [SIDE_W-1:0]      rect_height;
        logic [CELL_AW-1:0]     read_address;
    } item_t;

    class canvas_scoreboard;
        logic [23:0] palette_rgb [PAL_SIZE];
        logic [31:0] canvas_mem [CANVAS_CELLS];
        logic [31:0] pending_pixels [$];
        int cfg_width;
        int cfg_height;
        int cfg_bg;
        bit first_frame;
        bit keep_prev;
        int clear_slot;
        int frame_left;
        int frame_top;
        int frame_width;
        int frame_height;
        int cur_col;
        int cur_row;
        int failures;
        int shown;
        int checked;

        function new();
            foreach (palette_rgb[i])
            begin
                palette_rgb[i] = '0;
            end
            foreach (canvas_mem[i])
            begin
                canvas_mem[i] = '0;
            end
            cfg_width = MAX_SIDE;
            cfg_height = MAX_SIDE;
            cfg_bg = 0;
            first_frame = 1'b1;
            keep_prev = 1'b0;
            clear_slot = 256;
            frame_left = 0;
            frame_top = 0;
            frame_width = 0;
            frame_height = 0;
            cur_col = 0;
            cur_row = 0;
            failures = 0;
            shown = 0;
            checked = 0;
        endfunction

        function int side(int v);
            if (v < 1)
            begin
                return 1;
            end
            if (v > MAX_SIDE)
            begin
                return MAX_SIDE;
            end
            return v;
        endfunction

        function int eff_width();
            return side(cfg_width);
        endfunction

        function int eff_height();
            return side(cfg_height);
        endfunction

        function void set_config(int w, int h, int bg);
            cfg_width = w & 'h1FF;
            cfg_height = h & 'h1FF;
            cfg_bg = bg & 'hFF;
        endfunction

        function void fill_canvas(logic [31:0] v);
            foreach (canvas_mem[i])
            begin
                canvas_mem[i] = v;
            end
        endfunction

        function void apply_item(item_t it);
            logic [31:0] pix;
            logic [7:0] alpha;
            bit wr;
            int col;
            int row;
            pix = '0;
            case (it.op)
                OP_LOAD:
                begin
                    palette_rgb[it.color_index] = {it.red, it.green, it.blue};
                end
                OP_BEGIN:
                begin
                    frame_left = it.rect_left;
                    frame_top = it.rect_top;
                    frame_width = it.rect_width;
                    frame_height = it.rect_height;
                    clear_slot = it.transparency_on ? int'(it.color_index) : 256;
                    keep_prev = !first_frame && (it.disposal == DISP_KEEP);
                    cur_col = 0;
                    cur_row = 0;
                    if (first_frame || it.disposal == DISP_BACKGROUND)
                    begin
                        fill_canvas({palette_rgb[cfg_bg], ALPHA_OPAQUE});
                    end
                    else if (it.disposal != DISP_KEEP)
                    begin
                        fill_canvas('0);
                    end
                    first_frame = 1'b0;
                end
                OP_PIXEL:
                begin
                    if (cur_row < frame_height && cur_col < frame_width)
                    begin
                        col = frame_left + cur_col;
                        row = frame_top + cur_row;
                        wr = 1'b1;
                        alpha = ALPHA_OPAQUE;
                        if (int'(it.color_index) == clear_slot)
                        begin
                            wr = !keep_prev;
                            alpha = ALPHA_CLEAR;
                        end
                        if (wr && col < eff_width() && row < eff_height())
                        begin
                            canvas_mem[row * eff_width() + col] =
                                {palette_rgb[it.color_index], alpha};
                        end
                        cur_col++;
                        if (cur_col >= frame_width)
                        begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                end
                default:
                begin
                    if (int'(it.read_address) < eff_width() * eff_height())
                    begin
                        pix = canvas_mem[it.read_address];
                    end
                end
            endcase
            pending_pixels.push_back(pix);
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                  logic [7:0] a);
            logic [31:0] want;
            checked++;
            if (pending_pixels.size() == 0)
            begin
                failures++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected result item r=%h g=%h b=%h a=%h", r, g, b, a);
                end
                return;
            end
            want = pending_pixels.pop_front();
            if (want[31:24] !== r || want[23:16] !== g || want[15:8] !== b ||
                want[7:0] !== a)
            begin
                failures++;
                if (shown < 10)
                begin
                    shown++;
                    $display("result %0d: expected r=%h g=%h b=%h a=%h got r=%h g=%h b=%h a=%h",
                             checked, want[31:24], want[23:16], want[15:8], want[7:0],
                             r, g, b, a);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [1:0]            cfg_index;
    logic [SIDE_W-1:0]     cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            opcode;
    logic [7:0]            color_index;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [2:0]            disposal;
    logic                  transparency_on;
    logic [7:0]            rect_left;
    logic [7:0]            rect_top;
    logic [SIDE_W-1:0]     rect_width;
    logic [SIDE_W-1:0]     rect_height;
    logic [CELL_AW-1:0]    read_address;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic [7:0]            out_alpha;

    canvas_scoreboard sb;
    bit known [PAL_SIZE];
    logic [7:0] known_q [$];
    int accepted;
    int burst_left;
    int hold_left;
    int next_hold;
    int stall_mode;
    int stall_left;
    int last_left;
    int last_top;
    int last_w;
    int last_h;

    indexed_frame_compositor_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .color_index      (color_index),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .disposal         (disposal),
        .transparency_on  (transparency_on),
        .rect_left        (rect_left),
        .rect_top         (rect_top),
        .rect_width       (rect_width),
        .rect_height      (rect_height),
        .read_address     (read_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_red          (out_red),
        .out_green        (out_green),
        .out_blue         (out_blue),
        .out_alpha        (out_alpha)
    );

    always #1 clk = ~clk;

    // result checking and receiver stall pattern, with long hold-offs for back-pressure
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_pixel(out_red, out_green, out_blue, out_alpha);
        end
        if (sb.checked >= next_hold)
        begin
            hold_left = 300;
            next_hold = next_hold + 900;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    function automatic item_t any_item();
        item_t it;
        it.op = opcode_t'($urandom_range(0, 3));
        it.color_index = 8'($urandom);
        it.red = 8'($urandom);
        it.green = 8'($urandom);
        it.blue = 8'($urandom);
        it.disposal = 3'($urandom);
        it.transparency_on = 1'($urandom);
        it.rect_left = 8'($urandom);
        it.rect_top = 8'($urandom);
        it.rect_width = SIDE_W'($urandom);
        it.rect_height = SIDE_W'($urandom);
        it.read_address = CELL_AW'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] pick_known();
        return known_q[$urandom_range(0, known_q.size() - 1)];
    endfunction

    task automatic send(input item_t it);
        in_valid <= 1'b1;
        opcode <= it.op;
        color_index <= it.color_index;
        red <= it.red;
        green <= it.green;
        blue <= it.blue;
        disposal <= it.disposal;
        transparency_on <= it.transparency_on;
        rect_left <= it.rect_left;
        rect_top <= it.rect_top;
        rect_width <= it.rect_width;
        rect_height <= it.rect_height;
        read_address <= it.read_address;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.apply_item(it);
        accepted++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic load(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                        input logic [7:0] b);
        item_t it;
        it = any_item();
        it.op = OP_LOAD;
        it.color_index = idx;
        it.red = r;
        it.green = g;
        it.blue = b;
        send(it);
        if (!known[idx])
        begin
            known[idx] = 1'b1;
            known_q.push_back(idx);
        end
    endtask

    task automatic begin_frame(input logic [2:0] disp, input bit has_t, input logic [7:0] tidx,
                               input int l, input int t, input int w, input int h);
        item_t it;
        it = any_item();
        it.op = OP_BEGIN;
        it.disposal = disp;
        it.transparency_on = has_t;
        it.color_index = tidx;
        it.rect_left = 8'(l);
        it.rect_top = 8'(t);
        it.rect_width = SIDE_W'(w);
        it.rect_height = SIDE_W'(h);
        last_left = l;
        last_top = t;
        last_w = w;
        last_h = h;
        send(it);
    endtask

    task automatic pixel(input logic [7:0] idx);
        item_t it;
        it = any_item();
        it.op = OP_PIXEL;
        it.color_index = idx;
        send(it);
    endtask

    task automatic read_at(input int addr);
        item_t it;
        it = any_item();
        it.op = OP_READ;
        it.read_address = CELL_AW'(addr);
        send(it);
    endtask

    task automatic read_near();
        int c;
        int r;
        c = last_left + $urandom_range(0, (last_w > 8) ? 7 : ((last_w > 0) ? last_w - 1 : 0));
        r = last_top + $urandom_range(0, (last_h > 8) ? 7 : ((last_h > 0) ? last_h - 1 : 0));
        read_at(r * sb.eff_width() + c);
    endtask

    task automatic draw_frame(input logic [2:0] disp);
        int cols;
        int rows;
        int w;
        int h;
        int l;
        int t;
        int n;
        int sel;
        bit has_t;
        logic [7:0] tidx;
        cols = sb.eff_width();
        rows = sb.eff_height();
        sel = $urandom_range(0, 9);
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 5);
        if (sel == 0)
        begin
            w = $urandom_range(0, 511);
        end
        if (sel == 1)
        begin
            h = $urandom_range(0, 511);
        end
        l = (sel == 2) ? $urandom_range(0, 255) : $urandom_range(0, cols - 1);
        t = (sel == 3) ? $urandom_range(0, 255) : $urandom_range(0, rows - 1);
        has_t = 1'($urandom_range(0, 1));
        tidx = ($urandom_range(0, 3) != 0) ? pick_known() : 8'($urandom);
        begin_frame(disp, has_t, tidx, l, t, w, h);
        n = (w * h > 40) ? 40 : w * h;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            n = $urandom_range(0, n);
        end
        else if (sel == 1)
        begin
            n = n + $urandom_range(1, 4);
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                read_near();
            end
            pixel((has_t && known[tidx] && $urandom_range(0, 4) == 0) ? tidx : pick_known());
        end
        repeat ($urandom_range(1, 3)) read_near();
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic configure(input int w, input int h, input int bg);
        cfg_write <= 1'b1;
        cfg_index <= CFG_CANVAS_WIDTH;
        cfg_data <= SIDE_W'(w);
        @(posedge clk);
        cfg_index <= CFG_CANVAS_HEIGHT;
        cfg_data <= SIDE_W'(h);
        @(posedge clk);
        cfg_index <= CFG_BACKGROUND;
        cfg_data <= SIDE_W'(bg);
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_config(w, h, bg);
    endtask

    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        item_t it;
        int d;
        int w;
        int h;
        int bg;
        int sel;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_CANVAS_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_LOAD;
        color_index = '0;
        red = '0;
        green = '0;
        blue = '0;
        disposal = '0;
        transparency_on = 1'b0;
        rect_left = '0;
        rect_top = '0;
        rect_width = '0;
        rect_height = '0;
        read_address = '0;
        out_stall = 1'b0;
        accepted = 0;
        burst_left = 0;
        hold_left = 0;
        next_hold = 400;
        stall_mode = 0;
        stall_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(MAX_SIDE, MAX_SIDE, 0);
        load(8'd0, 8'hFF, 8'h00, 8'hFF);
        load(8'd255, 8'h00, 8'hFF, 8'h00);
        load(8'd1, 8'h80, 8'h7F, 8'h01);
        load(8'd128, 8'h01, 8'hFE, 8'h80);
        // pixel with no frame yet is dropped
        pixel(8'd1);
        // first frame fills with background even though it asks to keep
        begin_frame(DISP_KEEP, 1'b1, 8'd255, 0, 0, 2, 2);
        pixel(8'd1);
        pixel(8'd255);
        pixel(8'd128);
        pixel(8'd0);
        pixel(8'd1);
        read_at(0);
        read_at(1);
        read_at(257);
        read_at(65535);
        // keep mode, transparent skipped, rectangle running off the canvas
        begin_frame(DISP_KEEP, 1'b1, 8'd1, 254, 255, 4, 1);
        pixel(8'd1);
        pixel(8'd128);
        pixel(8'd0);
        pixel(8'd255);
        read_at(255 * 256 + 254);
        read_at(65535);
        // clear with a zero-width rectangle
        begin_frame(DISP_NONE, 1'b0, 8'd0, 0, 0, 0, 3);
        pixel(8'd1);
        read_at(0);
        begin_frame(DISP_BACKGROUND, 1'b0, 8'd0, 255, 0, 511, 256);
        pixel(8'd255);
        pixel(8'd1);
        read_at(255);
        settle();

        for (int p = 1; p <= 6; p++)
        begin
            case (p)
                1: begin w = 20; h = 12; bg = 255; end
                2: begin w = 0; h = 256; bg = pick_known(); end
                3: begin w = 511; h = 3; bg = 256 + pick_known(); end
                4: begin w = 256; h = 0; bg = pick_known(); end
                5: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64);
                          bg = pick_known(); end
                default: begin w = 100; h = 200; bg = pick_known(); end
            endcase
            configure(w, h, bg);
            if (p <= 5)
            begin
                d = p + 2;
            end
            else
            begin
                d = $urandom_range(0, 6);
                if (d != 0)
                begin
                    d = d + 1;
                end
            end
            draw_frame(3'(d));
            while (accepted < 29 + p * 287)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                begin
                    draw_frame(DISP_KEEP);
                end
                else if (sel < 75)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        read_near();
                    end
                    else
                    begin
                        read_at($urandom_range(0, 65535));
                    end
                end
                else if (sel < 85)
                begin
                    load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                end
                else
                begin
                    it = any_item();
                    if (it.op == OP_LOAD)
                    begin
                        load(it.color_index, it.red, it.green, it.blue);
                    end
                    else
                    begin
                        if (it.op == OP_BEGIN)
                        begin
                            it.disposal = DISP_KEEP;
                        end
                        if (it.op == OP_PIXEL)
                        begin
                            it.color_index = pick_known();
                        end
                        send(it);
                    end
                end
            end
            settle();
        end

        if (sb.failures == 0 && sb.pending_pixels.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
src/ifc_pkg.sv
src/indexed_frame_compositor_unit.sv
sim/indexed_frame_compositor_unit_tb.sv
